### src/pcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared widths, microcode encodings and the control store of the prime
// count sieve.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int MAX_LIMIT = 65536;
  localparam int NUM_W     = 17;
  localparam int ADDR_W    = 16;
  localparam int ROOT_W    = 9;
  localparam int STEP_W    = 4;
  localparam int OP_W      = 4;
  localparam int COND_W    = 3;
  localparam int TDATA_W   = 24;

  localparam logic [NUM_W-1:0] LIMIT_MAX = NUM_W'(MAX_LIMIT);

  localparam logic [STEP_W-1:0] ST_IDLE       = 4'd0;
  localparam logic [STEP_W-1:0] ST_CLR_INIT   = 4'd1;
  localparam logic [STEP_W-1:0] ST_CLR        = 4'd2;
  localparam logic [STEP_W-1:0] ST_SIEVE_INIT = 4'd3;
  localparam logic [STEP_W-1:0] ST_TEST       = 4'd4;
  localparam logic [STEP_W-1:0] ST_CHECK      = 4'd5;
  localparam logic [STEP_W-1:0] ST_MARK       = 4'd6;
  localparam logic [STEP_W-1:0] ST_NEXT_I     = 4'd7;
  localparam logic [STEP_W-1:0] ST_CNT_INIT   = 4'd8;
  localparam logic [STEP_W-1:0] ST_CNT        = 4'd9;
  localparam logic [STEP_W-1:0] ST_EMIT       = 4'd10;

  localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
  localparam logic [OP_W-1:0] OP_K_INIT     = 4'd2;
  localparam logic [OP_W-1:0] OP_CLR_WR     = 4'd3;
  localparam logic [OP_W-1:0] OP_SIEVE_INIT = 4'd4;
  localparam logic [OP_W-1:0] OP_READ_I     = 4'd5;
  localparam logic [OP_W-1:0] OP_SET_J      = 4'd6;
  localparam logic [OP_W-1:0] OP_MARK_WR    = 4'd7;
  localparam logic [OP_W-1:0] OP_NEXT_I     = 4'd8;
  localparam logic [OP_W-1:0] OP_CNT_INIT   = 4'd9;
  localparam logic [OP_W-1:0] OP_CNT_RD     = 4'd10;
  localparam logic [OP_W-1:0] OP_EMIT       = 4'd11;

  localparam logic [COND_W-1:0] CD_NEVER    = 3'd0;
  localparam logic [COND_W-1:0] CD_IN_IDLE  = 3'd1;
  localparam logic [COND_W-1:0] CD_K_GT_N   = 3'd2;
  localparam logic [COND_W-1:0] CD_SQ_GT_N  = 3'd3;
  localparam logic [COND_W-1:0] CD_MARKED   = 3'd4;
  localparam logic [COND_W-1:0] CD_J_GT_N   = 3'd5;
  localparam logic [COND_W-1:0] CD_OUT_BUSY = 3'd6;

  // The operation runs when the condition is false; the condition selects
  // the next step.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] tgt_true;
    logic [STEP_W-1:0] tgt_false;
  } pcs_uword_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } pcs_ctrl_t;

  typedef struct packed {
    logic k_gt_n;
    logic sq_gt_n;
    logic j_gt_n;
    logic marked;
  } pcs_flags_t;

  function automatic pcs_uword_t pcs_rom(input logic [STEP_W-1:0] step);
    pcs_uword_t w;
    w = '{OP_NOP, CD_NEVER, ST_IDLE, ST_IDLE};
    unique case (step)
      ST_IDLE:       w = '{OP_LOAD,       CD_IN_IDLE,  ST_IDLE,     ST_CLR_INIT};
      ST_CLR_INIT:   w = '{OP_K_INIT,     CD_NEVER,    ST_IDLE,     ST_CLR};
      ST_CLR:        w = '{OP_CLR_WR,     CD_K_GT_N,   ST_SIEVE_INIT, ST_CLR};
      ST_SIEVE_INIT: w = '{OP_SIEVE_INIT, CD_NEVER,    ST_IDLE,     ST_TEST};
      ST_TEST:       w = '{OP_READ_I,     CD_SQ_GT_N,  ST_CNT_INIT, ST_CHECK};
      ST_CHECK:      w = '{OP_SET_J,      CD_MARKED,   ST_NEXT_I,   ST_MARK};
      ST_MARK:       w = '{OP_MARK_WR,    CD_J_GT_N,   ST_NEXT_I,   ST_MARK};
      ST_NEXT_I:     w = '{OP_NEXT_I,     CD_NEVER,    ST_IDLE,     ST_TEST};
      ST_CNT_INIT:   w = '{OP_CNT_INIT,   CD_NEVER,    ST_IDLE,     ST_CNT};
      ST_CNT:        w = '{OP_CNT_RD,     CD_K_GT_N,   ST_EMIT,     ST_CNT};
      ST_EMIT:       w = '{OP_EMIT,       CD_OUT_BUSY, ST_EMIT,     ST_IDLE};
      default:       w = '{OP_NOP,        CD_NEVER,    ST_IDLE,     ST_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### src/prime_count_sieve_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prime_count_sieve_unit
// Counts the primes in 2..n for a requested limit n with a microcoded sieve.
// ----------------------------------------------------------------------------
// A request arrives on the s_ channel; its limit is taken from s_tdata and
// saturates to 65536. The result leaves on the m_ channel as one transaction
// carrying the prime count. One request is handled at a time: s_tready is
// high only while the sequencer waits in its idle step.
// The mark memory is cleared for 2..n at the start of each request, so no
// clearing pass follows reset and no request depends on an earlier one.
// Run time for a limit n is set by a clearing pass and a counting pass over
// 2..n, the test, check and advance steps of each sieve candidate i with
// i*i <= n, a closing mark step per sieve prime and one mark write per
// marked multiple, since the mark memory has a single write port and a
// single read port.
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver still stalls when the next count is ready, the
// sequencer holds in its emit step until the register is free.
// Reset returns the sequencer to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
module prime_count_sieve_unit
  import pcs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [TDATA_W-1:0] s_tdata,   // [16:0] limit
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata    // [16:0] prime_count
);

  pcs_ctrl_t         ctrl;
  pcs_flags_t        flags;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  count;
  logic              out_busy;

  assign out_busy = m_tvalid && !m_tready;
  assign s_tready = (step == ST_IDLE) && !rst;

  pcs_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_busy (out_busy),
    .flags    (flags),
    .ctrl     (ctrl),
    .step     (step)
  );

  pcs_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .limit (s_tdata[NUM_W-1:0]),
    .flags (flags),
    .count (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.op == OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT) begin
      m_tdata <= TDATA_W'(count);
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EMIT) |-> !out_busy)
    else $error("result emitted over a stalled transaction");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ctrl.op == OP_EMIT))
    else $error("m_tvalid rose without an emit step");

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken while one is in progress");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> (ctrl.op == OP_LOAD))
    else $error("accepted request was not loaded");

endmodule
`default_nettype wire

### src/pcs_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_sequencer
// Step counter and control store; evaluates the jump condition of each
// control word and issues its operation to the datapath.
// ----------------------------------------------------------------------------
module pcs_sequencer
  import pcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              out_busy,
  input  wire pcs_flags_t        flags,
  output pcs_ctrl_t              ctrl,
  output logic [STEP_W-1:0]      step
);

  logic [STEP_W-1:0] step_next;
  pcs_uword_t        word;
  logic              cond;

  assign word = pcs_rom(step);

  always_comb begin
    unique case (word.cond)
      CD_NEVER:    cond = 1'b0;
      CD_IN_IDLE:  cond = !in_valid;
      CD_K_GT_N:   cond = flags.k_gt_n;
      CD_SQ_GT_N:  cond = flags.sq_gt_n;
      CD_MARKED:   cond = flags.marked;
      CD_J_GT_N:   cond = flags.j_gt_n;
      CD_OUT_BUSY: cond = out_busy;
      default:     cond = 1'b0;
    endcase
  end

  assign step_next = cond ? word.tgt_true : word.tgt_false;
  assign ctrl.op   = cond ? OP_NOP : word.op;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

### src/pcs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_datapath
// Limit, sieve and count registers around a one-bit-per-number mark memory
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pcs_datapath
  import pcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pcs_ctrl_t        ctrl,
  input  wire logic [NUM_W-1:0] limit,
  output pcs_flags_t            flags,
  output logic [NUM_W-1:0]      count
);

  logic              marks [MAX_LIMIT];
  logic [NUM_W-1:0]  n;
  logic [NUM_W-1:0]  k;
  logic [NUM_W-1:0]  j;
  logic [NUM_W-1:0]  sq;
  logic [ROOT_W-1:0] i;
  logic              rd_data;
  logic              rd_pend;
  logic              wr_en;
  logic              wr_bit;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [NUM_W-1:0]  i_ext;

  assign i_ext = NUM_W'(i);

  assign flags.k_gt_n  = k > n;
  assign flags.sq_gt_n = sq > n;
  assign flags.j_gt_n  = j > n;
  assign flags.marked  = rd_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_bit  = 1'b0;
    wr_addr = ADDR_W'(k - 1'b1);
    case (ctrl.op)
      OP_CLR_WR: begin
        wr_en = 1'b1;
      end
      OP_MARK_WR: begin
        wr_en   = 1'b1;
        wr_bit  = 1'b1;
        wr_addr = ADDR_W'(j - 1'b1);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = (ctrl.op == OP_READ_I) ? ADDR_W'(i_ext - 1'b1) : ADDR_W'(k - 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      marks[wr_addr] <= wr_bit;
    end
    rd_data <= marks[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (ctrl.op == OP_CNT_RD);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend && !rd_data) begin
      count <= count + 1'b1;
    end
    case (ctrl.op)
      OP_LOAD: begin
        n <= (limit > LIMIT_MAX) ? LIMIT_MAX : limit;
      end
      OP_K_INIT: begin
        k <= NUM_W'(2);
      end
      OP_CLR_WR: begin
        k <= k + 1'b1;
      end
      OP_SIEVE_INIT: begin
        i  <= ROOT_W'(2);
        sq <= NUM_W'(4);
      end
      OP_SET_J: begin
        j <= sq;
      end
      OP_MARK_WR: begin
        j <= j + i_ext;
      end
      OP_NEXT_I: begin
        i  <= i + 1'b1;
        sq <= sq + {i_ext[NUM_W-2:0], 1'b1};
      end
      OP_CNT_INIT: begin
        k     <= NUM_W'(2);
        count <= '0;
      end
      OP_CNT_RD: begin
        k <= k + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
